// ===== rtl/hed_pkg.sv =====
`timescale 1ns / 1ps
package hed_pkg;

	localparam int PENDING_DEPTH_DEF = 7;
	localparam int NUM_ENT = 9;
	localparam int ENT_MAX = 7;

	localparam logic [15:0] CH_TAB       = 16'h0009;
	localparam logic [15:0] CH_NL        = 16'h000A;
	localparam logic [15:0] CH_CTL_LIMIT = 16'h0020;
	localparam logic [15:0] CH_QUOT      = 16'h0022;
	localparam logic [15:0] CH_AMP       = 16'h0026;
	localparam logic [15:0] CH_SLASH     = 16'h002F;
	localparam logic [15:0] CH_BSLASH    = 16'h005C;
	localparam logic [15:0] CH_LC_N      = 16'h006E;
	localparam logic [15:0] CH_LC_T      = 16'h0074;

	// entity names after the ampersand, ASCII, zero padded
	localparam logic [0:NUM_ENT-1][0:ENT_MAX-1][7:0] ENT_TXT = '{
		'{8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B, 8'h00, 8'h00},
		'{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00, 8'h00, 8'h00},
		'{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h63, 8'h6F, 8'h70, 8'h79, 8'h3B, 8'h00, 8'h00},
		'{8'h72, 8'h65, 8'h67, 8'h3B, 8'h00, 8'h00, 8'h00},
		'{8'h74, 8'h69, 8'h6D, 8'h65, 8'h73, 8'h3B, 8'h00},
		'{8'h64, 8'h69, 8'h76, 8'h69, 8'h64, 8'h65, 8'h3B}
	};
	localparam logic [0:NUM_ENT-1][2:0] ENT_LEN = '{
		3'd5, 3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd4, 3'd6, 3'd7
	};
	localparam logic [0:NUM_ENT-1][15:0] ENT_VAL = '{
		16'h0020, 16'h003C, 16'h003E, 16'h0026, 16'h0022,
		16'h00A9, 16'h00AE, 16'h00D7, 16'h00F7
	};

	typedef struct packed {
		logic load;
		logic step;
		logic flush;
		logic finish;
	} hed_cmd_t;

	typedef struct packed {
		logic scan_more;
		logic pend_any;
		logic last;
		logic can_emit;
		logic out_free;
	} hed_stat_t;

endpackage

// ===== rtl/hed_if.sv =====
`timescale 1ns / 1ps
interface hed_text_if;
	logic        valid;
	logic        ready;
	logic [15:0] in_char;
	logic        in_last;
	modport source(output valid, in_char, in_last, input ready);
	modport sink(input valid, in_char, in_last, output ready);
endinterface

interface hed_char_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_char;
	logic        has_char;
	logic        run_last;
	logic        string_end;
	modport source(output valid, out_char, has_char, run_last, string_end, input ready);
	modport sink(input valid, out_char, has_char, run_last, string_end, output ready);
endinterface

// ===== rtl/hed_datapath.sv =====
`timescale 1ns / 1ps
module hed_datapath import hed_pkg::*; #(
	parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  hed_cmd_t    cmd,
	output hed_stat_t   stat,
	input  logic [15:0] in_char,
	input  logic        in_last,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [15:0] out_char,
	output logic        has_char,
	output logic        run_last,
	output logic        string_end
);

	localparam int QLEN = PENDING_DEPTH + 1;
	localparam int IW   = $clog2(QLEN);
	localparam int LW   = $clog2(QLEN + 1);

	// entries below cnt_q are the held partial match, cnt_q..len_q-1 wait for scanning
	logic [15:0]   buf_q [QLEN];
	logic [LW-1:0] len_q;
	logic [IW-1:0] cnt_q;
	logic [15:0]   hold_q;
	logic          hold_v_q;
	logic          last_q;
	logic          out_v_q;
	logic [15:0]   out_char_q;
	logic          has_char_q;
	logic          run_last_q;
	logic          string_end_q;

	logic [15:0]   ch;
	logic [15:0]   lead;
	logic [IW-1:0] pos;
	logic          r_full;
	logic          r_more;
	logic [15:0]   r_val;
	logic          found;
	logic          ok;
	logic          emit_v;
	logic [15:0]   emit_c;
	logic [LW-1:0] sh;
	logic [IW-1:0] cnt_n;
	logic [15:0]   buf_sh [QLEN];
	logic          out_free;
	logic          out_load;
	logic [15:0]   out_char_n;
	logic          has_char_n;
	logic          run_last_n;
	logic          string_end_n;

	assign ch   = buf_q[cnt_q];
	assign lead = buf_q[0];
	assign pos  = cnt_q - IW'(1);

	// match the unit under scan against the held prefix
	always_comb begin
		r_full = 1'b0;
		r_more = 1'b0;
		r_val  = '0;
		found  = 1'b0;
		ok     = 1'b0;
		if (lead == CH_SLASH || lead == CH_BSLASH) begin
			if (cnt_q == IW'(1)) begin
				if (ch == CH_LC_N) begin
					r_full = 1'b1;
					r_val  = CH_NL;
				end else if (ch == CH_LC_T) begin
					r_full = 1'b1;
					r_val  = CH_TAB;
				end else if (ch == CH_QUOT) begin
					r_full = 1'b1;
					r_val  = CH_QUOT;
				end
			end
		end else if (lead == CH_AMP) begin
			for (int e = 0; e < NUM_ENT; e++) begin
				ok = IW'(ENT_LEN[e]) > pos;
				for (int k = 0; k < ENT_MAX - 1; k++) begin
					if (pos > IW'(k) && buf_q[k+1] != {8'h00, ENT_TXT[e][k]})
						ok = 1'b0;
				end
				if (!found && ok && {8'h00, ENT_TXT[e][pos[2:0]]} == ch) begin
					found = 1'b1;
					if (IW'(ENT_LEN[e]) == cnt_q) begin
						r_full = 1'b1;
						r_val  = ENT_VAL[e];
					end else begin
						r_more = cnt_q < IW'(PENDING_DEPTH);
					end
				end
			end
		end
	end

	// outcome of a scan step or a flush step
	always_comb begin
		emit_v = 1'b0;
		emit_c = '0;
		sh     = '0;
		cnt_n  = cnt_q;
		if (cmd.flush) begin
			emit_v = 1'b1;
			emit_c = lead;
			sh     = LW'(1);
			cnt_n  = cnt_q - IW'(1);
		end else if (cmd.step) begin
			if (cnt_q == '0) begin
				if (ch < CH_CTL_LIMIT && ch != CH_NL) begin
					sh = LW'(1);
				end else if (ch == CH_AMP || ch == CH_SLASH || ch == CH_BSLASH) begin
					cnt_n = IW'(1);
				end else begin
					emit_v = 1'b1;
					emit_c = ch;
					sh     = LW'(1);
				end
			end else if (r_full) begin
				emit_v = 1'b1;
				emit_c = r_val;
				sh     = LW'(cnt_q) + LW'(1);
				cnt_n  = '0;
			end else if (r_more) begin
				cnt_n = cnt_q + IW'(1);
			end else begin
				emit_v = 1'b1;
				emit_c = lead;
				sh     = LW'(1);
				cnt_n  = '0;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < QLEN; i++) begin
			if (i + int'(sh) < QLEN)
				buf_sh[i] = buf_q[i + int'(sh)];
			else
				buf_sh[i] = buf_q[i];
		end
	end

	// a new result pushes the held one out; finish closes the run
	assign out_free = !out_v_q || out_ready;
	always_comb begin
		out_load     = 1'b0;
		out_char_n   = hold_q;
		has_char_n   = 1'b1;
		run_last_n   = 1'b0;
		string_end_n = 1'b0;
		if (emit_v && hold_v_q) begin
			out_load = 1'b1;
		end else if (cmd.finish) begin
			if (hold_v_q) begin
				out_load     = 1'b1;
				run_last_n   = 1'b1;
				string_end_n = last_q;
			end else if (last_q) begin
				out_load     = 1'b1;
				out_char_n   = '0;
				has_char_n   = 1'b0;
				run_last_n   = 1'b1;
				string_end_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			cnt_q    <= '0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.load)
				len_q <= len_q + LW'(1);
			else if (cmd.step || cmd.flush)
				len_q <= len_q - sh;
			if (cmd.step || cmd.flush)
				cnt_q <= cnt_n;
			if (emit_v)
				hold_v_q <= 1'b1;
			else if (cmd.finish)
				hold_v_q <= 1'b0;
			if (out_load)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			buf_q[len_q[IW-1:0]] <= in_char;
			last_q               <= in_last;
		end else if (cmd.step || cmd.flush) begin
			buf_q <= buf_sh;
		end
		if (emit_v)
			hold_q <= emit_c;
		if (out_load) begin
			out_char_q   <= out_char_n;
			has_char_q   <= has_char_n;
			run_last_q   <= run_last_n;
			string_end_q <= string_end_n;
		end
	end

	assign stat.scan_more = len_q > LW'(cnt_q);
	assign stat.pend_any  = cnt_q != '0;
	assign stat.last      = last_q;
	assign stat.can_emit  = !hold_v_q || out_free;
	assign stat.out_free  = out_free;

	assign out_valid  = out_v_q;
	assign out_char   = out_char_q;
	assign has_char   = has_char_q;
	assign run_last   = run_last_q;
	assign string_end = string_end_q;

endmodule

// ===== rtl/hed_ctrl.sv =====
`timescale 1ns / 1ps
module hed_ctrl import hed_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  hed_stat_t stat,
	output hed_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_n;

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_more) begin
					cmd.step = stat.can_emit;
				end else if (stat.last && stat.pend_any) begin
					state_n = ST_FLUSH;
				end else if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_n    = ST_IDLE;
				end else begin
					state_n = ST_DONE;
				end
			end
			ST_FLUSH: begin
				if (stat.pend_any) begin
					cmd.flush = stat.can_emit;
				end else if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_n    = ST_IDLE;
				end else begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

endmodule

// ===== rtl/html_entity_escape_decoder.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Request payload                              Handshake
// text      in   in_char[15:0], in_last                       valid/ready
// decoded   out  out_char[15:0], has_char, run_last,          valid/ready
//                string_end
//
// A plain code unit passes through accept, a scan step and the close of its run.
// Each unit rescanned after a mismatch takes a further step. At the end of a
// string with a partial match held, the control enters the flush state and
// every held unit then takes a flush step. Steps run on the single match
// unit in the datapath, one working buffer unit per cycle unless output stalls.
// Reset clears the buffer fill, the match length and both output stages.
// With a result held, a full output register holds the scan; input is taken only between runs.
module html_entity_escape_decoder import hed_pkg::*; #(
	parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	hed_text_if.sink   text,
	hed_char_if.source decoded
);

	hed_cmd_t  cmd;
	hed_stat_t stat;

	// sequence accept, scan, flush and close of each request
	hed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text.valid),
		.in_ready (text.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// hold the partial match, scan queued units, stage results for the output
	hed_datapath #(
		.PENDING_DEPTH (PENDING_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_char    (text.in_char),
		.in_last    (text.in_last),
		.out_ready  (decoded.ready),
		.out_valid  (decoded.valid),
		.out_char   (decoded.out_char),
		.has_char   (decoded.has_char),
		.run_last   (decoded.run_last),
		.string_end (decoded.string_end)
	);

endmodule
